>>> rtl/wdm_pkg.sv
// wdm_pkg: shared types, codes and constants of the wheel distance monitor
// no dependencies; imported by every module under rtl
package wdm_pkg;

    localparam int DISTANCE_BITS    = 32;
    localparam int FAULT_COUNT_BITS = 16;

    localparam int POLE_BITS        = 8;
    localparam int CIRC_BITS        = 16;
    localparam int THRESH_BITS      = 32;
    localparam int LIMIT_BITS       = 16;
    localparam int OUT_DIST_BITS    = 32;

    localparam int DIFF_CMP_BITS  = (DISTANCE_BITS > THRESH_BITS) ? DISTANCE_BITS : THRESH_BITS;
    localparam int FAULT_CMP_BITS = (FAULT_COUNT_BITS > LIMIT_BITS) ? FAULT_COUNT_BITS
                                                                     : LIMIT_BITS;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRONT_POLE_COUNT  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REAR_POLE_COUNT   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRONT_CIRC        = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REAR_CIRC         = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIFF_UP_THRESH    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIFF_DOWN_THRESH  = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FAULT_COUNT_LIMIT = 3'd6;

    localparam logic [POLE_BITS-1:0]   RST_POLE_COUNT  = 8'd1;
    localparam logic [CIRC_BITS-1:0]   RST_CIRC        = 16'd2100;
    localparam logic [THRESH_BITS-1:0] RST_UP_THRESH   = 32'd1000;
    localparam logic [THRESH_BITS-1:0] RST_DOWN_THRESH = 32'd500;
    localparam logic [LIMIT_BITS-1:0]  RST_FAULT_LIMIT = 16'd100;

    localparam logic [POLE_BITS-1:0] MIN_POSITION = 8'd10;

    localparam logic [1:0] ACT_PULSE  = 2'd0;
    localparam logic [1:0] ACT_UPDATE = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [1:0] SENSOR_OK     = 2'd1;
    localparam logic [1:0] SENSOR_FAULTY = 2'd2;

    localparam logic [1:0] ST_NOT_AVAIL = 2'd0;
    localparam logic [1:0] ST_OK        = 2'd1;
    localparam logic [1:0] ST_ERROR     = 2'd2;
    localparam logic [1:0] ST_PERMANENT = 2'd3;

    typedef struct packed {
        logic [1:0]           action;
        logic                 pulse_channel;
        logic [POLE_BITS-1:0] sample_position;
        logic [1:0]           front_sensor_state;
        logic [1:0]           rear_sensor_state;
    } item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [OUT_DIST_BITS-1:0] distance;
        logic [OUT_DIST_BITS-1:0] front_distance_out;
        logic [OUT_DIST_BITS-1:0] rear_distance_out;
    } result_t;

    typedef struct packed {
        logic [POLE_BITS-1:0]   front_pole_count;
        logic [POLE_BITS-1:0]   rear_pole_count;
        logic [CIRC_BITS-1:0]   front_circumference;
        logic [CIRC_BITS-1:0]   rear_circumference;
        logic [THRESH_BITS-1:0] diff_up_threshold;
        logic [THRESH_BITS-1:0] diff_down_threshold;
        logic [LIMIT_BITS-1:0]  fault_count_limit;
    } cfg_t;

endpackage

>>> rtl/wheel_distance_monitor.sv
// wheel_distance_monitor: top level with input register, core and result register
// depends on wdm_pkg, wdm_cfg and wdm_core
//
//   channel   signals                                   transaction
//   item      item_valid, item_ready, item               one pulse, update or clear command
//   result    result_valid, result_ready, result         status and distances after the command
//   config    cfg_write, cfg_index, cfg_data             one register write, no handshake
//
// one transaction per cycle sustained while result_ready is held high; an accepted item passes
// through the input register, then through the state update into the result register
// a stalled result holds the result register and the item waiting in the input register,
// so two items can be in flight before item_ready drops
// rst_n clears status, distances, pole positions, fault counter and loads register defaults
module wheel_distance_monitor (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  wdm_pkg::item_t                      item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output wdm_pkg::result_t                    result,
    input  logic                                cfg_write,
    input  logic [wdm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [wdm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import wdm_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t core_result;
    result_t result_reg;
    logic    result_valid_reg;
    logic    advance;

    assign advance    = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || advance;

    wdm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wdm_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
                item_valid_reg <= item_valid;
            if (advance)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            item_reg <= item;
        if (advance)
            result_reg <= core_result;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> rtl/wdm_cfg.sv
// wdm_cfg: configuration register file of the wheel distance monitor
// depends on wdm_pkg
module wdm_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [wdm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [wdm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output wdm_pkg::cfg_t                       cfg
);
    import wdm_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.front_pole_count    <= RST_POLE_COUNT;
            cfg_reg.rear_pole_count     <= RST_POLE_COUNT;
            cfg_reg.front_circumference <= RST_CIRC;
            cfg_reg.rear_circumference  <= RST_CIRC;
            cfg_reg.diff_up_threshold   <= RST_UP_THRESH;
            cfg_reg.diff_down_threshold <= RST_DOWN_THRESH;
            cfg_reg.fault_count_limit   <= RST_FAULT_LIMIT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRONT_POLE_COUNT:  cfg_reg.front_pole_count    <= cfg_data[POLE_BITS-1:0];
                REG_REAR_POLE_COUNT:   cfg_reg.rear_pole_count     <= cfg_data[POLE_BITS-1:0];
                REG_FRONT_CIRC:        cfg_reg.front_circumference <= cfg_data[CIRC_BITS-1:0];
                REG_REAR_CIRC:         cfg_reg.rear_circumference  <= cfg_data[CIRC_BITS-1:0];
                REG_DIFF_UP_THRESH:    cfg_reg.diff_up_threshold   <= cfg_data[THRESH_BITS-1:0];
                REG_DIFF_DOWN_THRESH:  cfg_reg.diff_down_threshold <= cfg_data[THRESH_BITS-1:0];
                REG_FAULT_COUNT_LIMIT: cfg_reg.fault_count_limit   <= cfg_data[LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/wdm_core.sv
// wdm_core: wheel state, pole counting, distance accumulation and status machine
// depends on wdm_pkg; result is the state after the step, registered by the top level
module wdm_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  wdm_pkg::item_t   item,
    input  wdm_pkg::cfg_t    cfg,
    output wdm_pkg::result_t result
);
    import wdm_pkg::*;

    logic [1:0]                  status_reg, status_next;
    logic [DISTANCE_BITS-1:0]    front_dist_reg, front_dist_next;
    logic [DISTANCE_BITS-1:0]    rear_dist_reg, rear_dist_next;
    logic [POLE_BITS-1:0]        front_pos_reg, front_pos_next;
    logic [POLE_BITS-1:0]        rear_pos_reg, rear_pos_next;
    logic [FAULT_COUNT_BITS-1:0] fault_cnt_reg, fault_cnt_next;

    logic                        pos_valid;
    logic                        front_inc, rear_inc;
    logic [POLE_BITS-1:0]        front_pos_adv, rear_pos_adv;
    logic [DISTANCE_BITS-1:0]    diff;
    logic                        diff_above, diff_below;
    logic                        both_bad;
    logic                        below_limit;
    logic [FAULT_COUNT_BITS-1:0] fault_cnt_chk;
    logic                        at_limit;
    logic [1:0]                  status_chk;
    logic [DISTANCE_BITS-1:0]    larger_dist;

    assign pos_valid     = item.sample_position > MIN_POSITION;
    assign front_inc     = pos_valid && (item.pulse_channel == 1'b0
                                         || item.front_sensor_state != SENSOR_OK);
    assign rear_inc      = pos_valid && (item.pulse_channel == 1'b1
                                         || item.rear_sensor_state != SENSOR_OK);
    assign front_pos_adv = front_pos_reg + POLE_BITS'(front_inc);
    assign rear_pos_adv  = rear_pos_reg + POLE_BITS'(rear_inc);

    assign diff       = front_dist_reg - rear_dist_reg;
    assign diff_above = DIFF_CMP_BITS'(diff) > DIFF_CMP_BITS'(cfg.diff_up_threshold);
    assign diff_below = DIFF_CMP_BITS'(diff) < DIFF_CMP_BITS'(cfg.diff_down_threshold);

    // leaky counter of double sensor faults
    assign both_bad    = item.front_sensor_state >= SENSOR_FAULTY
                         && item.rear_sensor_state >= SENSOR_FAULTY;
    assign below_limit = FAULT_CMP_BITS'(fault_cnt_reg) < FAULT_CMP_BITS'(cfg.fault_count_limit)
                         && fault_cnt_reg != '1;

    always_comb
    begin
        if (both_bad && below_limit)
            fault_cnt_chk = fault_cnt_reg + FAULT_COUNT_BITS'(1);
        else if (fault_cnt_reg != '0)
            fault_cnt_chk = fault_cnt_reg - FAULT_COUNT_BITS'(1);
        else
            fault_cnt_chk = fault_cnt_reg;
    end

    assign at_limit   = FAULT_CMP_BITS'(fault_cnt_chk) >= FAULT_CMP_BITS'(cfg.fault_count_limit);
    assign status_chk = at_limit ? ST_PERMANENT : status_reg;

    always_comb
    begin
        status_next    = status_reg;
        front_dist_next = front_dist_reg;
        rear_dist_next = rear_dist_reg;
        front_pos_next = front_pos_reg;
        rear_pos_next  = rear_pos_reg;
        fault_cnt_next = fault_cnt_reg;
        unique case (item.action)
            ACT_PULSE:
            begin
                if (status_reg != ST_NOT_AVAIL)
                begin
                    if (front_pos_adv >= cfg.front_pole_count)
                    begin
                        front_dist_next = front_dist_reg
                                          + DISTANCE_BITS'(cfg.front_circumference);
                        front_pos_next  = '0;
                    end
                    else
                        front_pos_next  = front_pos_adv;
                    if (rear_pos_adv >= cfg.rear_pole_count)
                    begin
                        rear_dist_next = rear_dist_reg
                                         + DISTANCE_BITS'(cfg.rear_circumference);
                        rear_pos_next  = '0;
                    end
                    else
                        rear_pos_next  = rear_pos_adv;
                end
            end
            ACT_UPDATE:
            begin
                unique case (status_reg)
                    ST_NOT_AVAIL: status_next = ST_OK;
                    ST_OK:
                    begin
                        fault_cnt_next = fault_cnt_chk;
                        status_next    = diff_above ? ST_ERROR : status_chk;
                    end
                    ST_ERROR:
                    begin
                        fault_cnt_next = fault_cnt_chk;
                        status_next    = diff_below ? ST_OK : status_chk;
                    end
                    default: ;
                endcase
            end
            ACT_CLEAR:
            begin
                status_next     = ST_NOT_AVAIL;
                front_dist_next = '0;
                rear_dist_next  = '0;
                front_pos_next  = '0;
                rear_pos_next   = '0;
                fault_cnt_next  = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg     <= ST_NOT_AVAIL;
            front_dist_reg <= '0;
            rear_dist_reg  <= '0;
            front_pos_reg  <= '0;
            rear_pos_reg   <= '0;
            fault_cnt_reg  <= '0;
        end
        else if (step)
        begin
            status_reg     <= status_next;
            front_dist_reg <= front_dist_next;
            rear_dist_reg  <= rear_dist_next;
            front_pos_reg  <= front_pos_next;
            rear_pos_reg   <= rear_pos_next;
            fault_cnt_reg  <= fault_cnt_next;
        end
    end

    assign larger_dist = (front_dist_next > rear_dist_next) ? front_dist_next : rear_dist_next;

    assign result.status             = status_next;
    assign result.distance           = OUT_DIST_BITS'(larger_dist);
    assign result.front_distance_out = OUT_DIST_BITS'(front_dist_next);
    assign result.rear_distance_out  = OUT_DIST_BITS'(rear_dist_next);

endmodule

>>> verif/tb_wheel_distance_monitor.sv
// tb_wheel_distance_monitor: self-checking testbench for the wheel distance monitor
// needs wdm_pkg and wheel_distance_monitor from rtl; predicts every result and compares
// directed pulse, update and clear transactions first, then random phases under several configs
module tb_wheel_distance_monitor;
    timeunit 1ns;
    timeprecision 1ps;
    import wdm_pkg::*;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam logic [1:0] SENSOR_OFF   = 2'd0;
    localparam logic [1:0] SENSOR_UNDEF = 2'd3;
    localparam logic       WHEEL_FRONT  = 1'b0;
    localparam logic       WHEEL_REAR   = 1'b1;
    localparam int         MAX_REPORTS  = 10;
    localparam int         DRAIN_CYCLES = 4;
    localparam int         HOLD_AFTER   = 80;
    localparam int         HOLD_CYCLES  = 50;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      item_valid   = 1'b0;
    logic                      item_ready;
    item_t                     item         = '0;
    logic                      result_valid;
    logic                      result_ready = 1'b0;
    result_t                   result;
    logic                      cfg_write    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;

    item_t   pending_items[$];
    result_t expected_results[$];
    int      tx_idle_pct    = 0;
    int      rx_idle_pct    = 0;
    int      items_accepted = 0;
    int      mismatch_count = 0;
    logic    item_fire      = 1'b0;
    bit      fault_spell    = 1'b0;

    cfg_t shadow_cfg = '{RST_POLE_COUNT, RST_POLE_COUNT, RST_CIRC, RST_CIRC,
                         RST_UP_THRESH, RST_DOWN_THRESH, RST_FAULT_LIMIT};

    logic [1:0]                  wheel_status = ST_NOT_AVAIL;
    logic [DISTANCE_BITS-1:0]    front_dist   = '0;
    logic [DISTANCE_BITS-1:0]    rear_dist    = '0;
    logic [POLE_BITS-1:0]        front_pole   = '0;
    logic [POLE_BITS-1:0]        rear_pole    = '0;
    logic [FAULT_COUNT_BITS-1:0] fault_level  = '0;

    wheel_distance_monitor u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void tally_faults(input logic [1:0] fs, input logic [1:0] rs);
        if (fs >= SENSOR_FAULTY && rs >= SENSOR_FAULTY
            && fault_level < shadow_cfg.fault_count_limit && fault_level != '1)
            fault_level = fault_level + FAULT_COUNT_BITS'(1);
        else if (fault_level != '0)
            fault_level = fault_level - FAULT_COUNT_BITS'(1);
        if (fault_level >= shadow_cfg.fault_count_limit)
            wheel_status = ST_PERMANENT;
    endfunction

    function automatic result_t advance_wheels(input item_t it);
        logic [DISTANCE_BITS-1:0] gap;
        result_t                  r;
        gap = front_dist - rear_dist;
        case (it.action)
            ACT_PULSE:
                if (wheel_status != ST_NOT_AVAIL)
                begin
                    if (it.sample_position > MIN_POSITION)
                    begin
                        if (it.pulse_channel == WHEEL_FRONT || it.front_sensor_state != SENSOR_OK)
                            front_pole = front_pole + POLE_BITS'(1);
                        if (it.pulse_channel == WHEEL_REAR || it.rear_sensor_state != SENSOR_OK)
                            rear_pole = rear_pole + POLE_BITS'(1);
                    end
                    if (front_pole >= shadow_cfg.front_pole_count)
                    begin
                        front_dist = front_dist
                                     + DISTANCE_BITS'(shadow_cfg.front_circumference);
                        front_pole = '0;
                    end
                    if (rear_pole >= shadow_cfg.rear_pole_count)
                    begin
                        rear_dist = rear_dist
                                    + DISTANCE_BITS'(shadow_cfg.rear_circumference);
                        rear_pole = '0;
                    end
                end
            ACT_UPDATE:
                case (wheel_status)
                    ST_NOT_AVAIL:
                        wheel_status = ST_OK;
                    ST_OK:
                    begin
                        tally_faults(it.front_sensor_state, it.rear_sensor_state);
                        if (gap > shadow_cfg.diff_up_threshold)
                            wheel_status = ST_ERROR;
                    end
                    ST_ERROR:
                    begin
                        tally_faults(it.front_sensor_state, it.rear_sensor_state);
                        if (gap < shadow_cfg.diff_down_threshold)
                            wheel_status = ST_OK;
                    end
                    default:
                        ;
                endcase
            ACT_CLEAR:
            begin
                wheel_status = ST_NOT_AVAIL;
                front_dist   = '0;
                rear_dist    = '0;
                front_pole   = '0;
                rear_pole    = '0;
                fault_level  = '0;
            end
            default:
                ;
        endcase
        r.status             = wheel_status;
        r.distance           = (front_dist > rear_dist) ? front_dist : rear_dist;
        r.front_distance_out = front_dist;
        r.rear_distance_out  = rear_dist;
        return r;
    endfunction

    function automatic logic [1:0] pick_sensor(input bit bad);
        int roll;
        roll = $urandom_range(99);
        if (bad)
            return (roll < 60) ? SENSOR_FAULTY : SENSOR_UNDEF;
        if (roll < 55)
            return SENSOR_OK;
        if (roll < 75)
            return SENSOR_FAULTY;
        if (roll < 90)
            return SENSOR_OFF;
        return SENSOR_UNDEF;
    endfunction

    // double faults come in spells so the leaky counter can climb
    function automatic item_t random_item();
        item_t it;
        int    roll;
        if ($urandom_range(99) < 6)
            fault_spell = !fault_spell;
        roll = $urandom_range(99);
        if (roll < 58)
            it.action = ACT_PULSE;
        else if (roll < 90)
            it.action = ACT_UPDATE;
        else if (roll < 96)
            it.action = ACT_CLEAR;
        else
            it.action = ACT_UNUSED;
        it.pulse_channel = 1'($urandom_range(1));
        if ($urandom_range(99) < 80)
            it.sample_position = POLE_BITS'($urandom_range(255, 11));
        else
            it.sample_position = POLE_BITS'($urandom_range(10));
        it.front_sensor_state = pick_sensor(fault_spell);
        it.rear_sensor_state  = pick_sensor(fault_spell);
        return it;
    endfunction

    function automatic void push_item(input logic [1:0] act, input logic ch,
                                      input logic [POLE_BITS-1:0] pos,
                                      input logic [1:0] fs, input logic [1:0] rs);
        item_t it;
        it.action             = act;
        it.pulse_channel      = ch;
        it.sample_position    = pos;
        it.front_sensor_state = fs;
        it.rear_sensor_state  = rs;
        pending_items.push_back(it);
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_FRONT_POLE_COUNT:  shadow_cfg.front_pole_count    = val[POLE_BITS-1:0];
            REG_REAR_POLE_COUNT:   shadow_cfg.rear_pole_count     = val[POLE_BITS-1:0];
            REG_FRONT_CIRC:        shadow_cfg.front_circumference = val[CIRC_BITS-1:0];
            REG_REAR_CIRC:         shadow_cfg.rear_circumference  = val[CIRC_BITS-1:0];
            REG_DIFF_UP_THRESH:    shadow_cfg.diff_up_threshold   = val[THRESH_BITS-1:0];
            REG_DIFF_DOWN_THRESH:  shadow_cfg.diff_down_threshold = val[THRESH_BITS-1:0];
            REG_FAULT_COUNT_LIMIT: shadow_cfg.fault_count_limit   = val[LIMIT_BITS-1:0];
            default:               ;
        endcase
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || item_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input cfg_t c, input int tx_pct, input int rx_pct,
                             input int count);
        write_reg(REG_FRONT_POLE_COUNT, CFG_DATA_BITS'(c.front_pole_count));
        write_reg(REG_REAR_POLE_COUNT, CFG_DATA_BITS'(c.rear_pole_count));
        write_reg(REG_FRONT_CIRC, CFG_DATA_BITS'(c.front_circumference));
        write_reg(REG_REAR_CIRC, CFG_DATA_BITS'(c.rear_circumference));
        write_reg(REG_DIFF_UP_THRESH, CFG_DATA_BITS'(c.diff_up_threshold));
        write_reg(REG_DIFF_DOWN_THRESH, CFG_DATA_BITS'(c.diff_down_threshold));
        write_reg(REG_FAULT_COUNT_LIMIT, CFG_DATA_BITS'(c.fault_count_limit));
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count) pending_items.push_back(random_item());
        wait_drained();
    endtask

    // item driver
    always @(negedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (!item_valid || item_fire)
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                item       <= pending_items.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // result ready, with one long hold-off so the block backs up
    always @(negedge clk)
    begin : ready_driver
        int  hold_left;
        bit  hold_done;
        if (hold_left > 0)
        begin
            hold_left    = hold_left - 1;
            result_ready <= 1'b0;
        end
        else if (!hold_done && items_accepted >= HOLD_AFTER)
        begin
            hold_done    = 1'b1;
            hold_left    = HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // transaction monitor
    always @(posedge clk)
    begin : monitor
        result_t want;
        item_fire <= item_valid && item_ready;
        if (rst_n && item_valid && item_ready)
        begin
            expected_results.push_back(advance_wheels(item));
            items_accepted = items_accepted + 1;
        end
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: status %0d distance %h front %h rear %h",
                             result.status, result.distance,
                             result.front_distance_out, result.rear_distance_out);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.status !== want.status || result.distance !== want.distance
                    || result.front_distance_out !== want.front_distance_out
                    || result.rear_distance_out !== want.rear_distance_out)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch (exp/got): status %0d/%0d distance %h/%h %s %h/%h %s %h/%h",
                                 want.status, result.status, want.distance, result.distance,
                                 "front", want.front_distance_out, result.front_distance_out,
                                 "rear", want.rear_distance_out, result.rear_distance_out);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb_wheel_distance_monitor: errors");
        $finish;
    end

    initial
    begin
        cfg_t phase_cfg;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        tx_idle_pct = 16;
        rx_idle_pct = 72;

        // register defaults from reset
        push_item(ACT_PULSE, WHEEL_FRONT, 8'd255, SENSOR_OK, SENSOR_OK);
        push_item(ACT_UPDATE, WHEEL_FRONT, 8'd0, SENSOR_OK, SENSOR_OK);
        push_item(ACT_PULSE, WHEEL_FRONT, 8'd11, SENSOR_OK, SENSOR_OK);
        push_item(ACT_PULSE, WHEEL_FRONT, 8'd10, SENSOR_OK, SENSOR_OK);
        push_item(ACT_PULSE, WHEEL_REAR, 8'd0, SENSOR_OK, SENSOR_OK);
        push_item(ACT_PULSE, WHEEL_REAR, 8'd255, SENSOR_OK, SENSOR_OK);
        push_item(ACT_PULSE, WHEEL_FRONT, 8'd200, SENSOR_OK, SENSOR_FAULTY);
        push_item(ACT_PULSE, WHEEL_REAR, 8'd99, SENSOR_OFF, SENSOR_OK);
        push_item(ACT_PULSE, WHEEL_FRONT, 8'd128, SENSOR_OK, SENSOR_UNDEF);
        push_item(ACT_PULSE, WHEEL_FRONT, 8'd50, SENSOR_OK, SENSOR_OK);
        push_item(ACT_UPDATE, WHEEL_REAR, 8'd255, SENSOR_FAULTY, SENSOR_FAULTY);
        push_item(ACT_UPDATE, WHEEL_FRONT, 8'd1, SENSOR_UNDEF, SENSOR_UNDEF);
        push_item(ACT_UPDATE, WHEEL_FRONT, 8'd0, SENSOR_OK, SENSOR_OK);
        push_item(ACT_PULSE, WHEEL_REAR, 8'd77, SENSOR_OK, SENSOR_OK);
        push_item(ACT_UPDATE, WHEEL_FRONT, 8'd0, SENSOR_OK, SENSOR_OK);
        push_item(ACT_PULSE, WHEEL_REAR, 8'd77, SENSOR_OK, SENSOR_OK);
        push_item(ACT_UPDATE, WHEEL_FRONT, 8'd0, SENSOR_OFF, SENSOR_OFF);
        push_item(ACT_UNUSED, WHEEL_REAR, 8'd255, SENSOR_UNDEF, SENSOR_UNDEF);
        push_item(ACT_CLEAR, WHEEL_FRONT, 8'd0, SENSOR_OK, SENSOR_OK);
        push_item(ACT_UPDATE, WHEEL_FRONT, 8'd0, SENSOR_OK, SENSOR_OK);
        wait_drained();

        // zero fault limit: permanent on update, and overwritten by the difference check
        write_reg(REG_FAULT_COUNT_LIMIT, '0);
        push_item(ACT_UPDATE, WHEEL_FRONT, 8'd0, SENSOR_OK, SENSOR_OK);
        push_item(ACT_UPDATE, WHEEL_FRONT, 8'd0, SENSOR_FAULTY, SENSOR_FAULTY);
        push_item(ACT_PULSE, WHEEL_FRONT, 8'd255, SENSOR_OK, SENSOR_OK);
        push_item(ACT_CLEAR, WHEEL_REAR, 8'd255, SENSOR_UNDEF, SENSOR_OFF);
        push_item(ACT_UPDATE, WHEEL_FRONT, 8'd0, SENSOR_OK, SENSOR_OK);
        push_item(ACT_PULSE, WHEEL_FRONT, 8'd11, SENSOR_OK, SENSOR_OK);
        push_item(ACT_UPDATE, WHEEL_FRONT, 8'd0, SENSOR_OK, SENSOR_OK);
        wait_drained();

        phase_cfg = '{8'd3, 8'd4, 16'd2100, 16'd2000, 32'd5000, 32'd1000, 16'd4};
        run_phase(phase_cfg, 16, 72, 170);
        phase_cfg = '{8'd0, 8'd255, 16'hFFFF, 16'd0, 32'd0, 32'hFFFF_FFFF, 16'd0};
        run_phase(phase_cfg, 72, 16, 170);
        phase_cfg = '{8'd1, 8'd2, 16'd2900, 16'd3000, 32'd6000, 32'd600, 16'hFFFF};
        run_phase(phase_cfg, 0, 0, 160);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("tb_wheel_distance_monitor: clean");
        else
            $display("tb_wheel_distance_monitor: errors");
        $finish;
    end

endmodule
